// ===== rtl/pbpm_pkg.sv =====
`timescale 1ns / 1ps
package pbpm_pkg;

   localparam logic [1:0] REQ_FETCH = 2'd0;
   localparam logic [1:0] REQ_UNPIN = 2'd1;
   localparam logic [1:0] REQ_FLUSH = 2'd2;
   localparam logic [1:0] REQ_NEW   = 2'd3;

   localparam logic [2:0] ST_OK           = 3'd0;
   localparam logic [2:0] ST_NOT_RESIDENT = 3'd1;
   localparam logic [2:0] ST_NOT_PINNED   = 3'd2;
   localparam logic [2:0] ST_NO_FRAME     = 3'd3;
   localparam logic [2:0] ST_PIN_LIMIT    = 3'd4;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] page_id;
      logic        dirty;
   } req_type_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  frame_index;
      logic        read_needed;
      logic        clear_needed;
      logic        write_needed;
      logic [31:0] write_page_id;
   } rsp_type;

endpackage

// ===== rtl/pbpm_ram.sv =====
`timescale 1ns / 1ps
module pbpm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== rtl/pbpm_front.sv =====
`timescale 1ns / 1ps
// request register and one-entry queue toward the engine
module pbpm_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  pbpm_pkg::req_type_type      req_item,
   output logic                        busy,
   output logic                        q_valid,
   output pbpm_pkg::req_type_type      q_item,
   input  logic                        q_take
);
   logic                   valid_ff, valid_in;
   pbpm_pkg::req_type_type item_ff, item_in;

   assign busy    = valid_ff;
   assign q_valid = valid_ff;
   assign q_item  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (q_take) begin
         valid_in = 1'b0;
      end
      if (start && !valid_ff) begin
         valid_in = 1'b1;
         item_in  = req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end
endmodule

// ===== rtl/pbpm_engine.sv =====
`timescale 1ns / 1ps
module pbpm_engine #(
   parameter int FRAMES   = 16,
   parameter int PIN_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  pbpm_pkg::req_type_type q_item,
   output logic                   q_take,
   output logic                   rsp_valid,
   output pbpm_pkg::rsp_type      rsp_item
);
   localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int CW = $clog2(FRAMES + 1);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_SCAN   = 5'b00010,
      S_DECIDE = 5'b00100,
      S_REM    = 5'b01000,
      S_DONE   = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [FW-1:0] rd_addr;
   logic [31:0]   rd_data;
   logic          wr_en;
   logic [FW-1:0] wr_addr;

   logic [FRAMES-1:0]   used_ff, used_in, dirty_ff, dirty_in;
   logic [PIN_BITS-1:0] pin_ff [FRAMES];
   logic [PIN_BITS-1:0] pin_in [FRAMES];
   logic [CW-1:0]       rank_ff [FRAMES];
   logic [CW-1:0]       rank_in [FRAMES];
   logic [CW-1:0]       fresh_ff, fresh_in, top_ff, top_in;
   logic                hit_ff, hit_in, vic_ok_ff, vic_ok_in;
   logic [FW-1:0]       hit_f_ff, hit_f_in, vic_ff, vic_in;
   logic [FW-1:0]       g_ff, g_in;
   logic [CW-1:0]       rem_r_ff, rem_r_in;
   logic                rem_ff, rem_in;
   pbpm_pkg::rsp_type   out_ff, out_in;
   logic                strobe_ff, strobe_in;
   logic [FW-1:0]       scan_f;
   logic [PIN_BITS-1:0] pc;

   // page table memory, one read per scan step, victim page read on remove
   pbpm_ram #(.WIDTH(32), .DEPTH(FRAMES)) u_pages (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (q_item.page_id),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid = strobe_ff;
   assign rsp_item  = out_ff;
   assign scan_f    = FW'(idx_ff - CW'(1));

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      used_in   = used_ff;
      dirty_in  = dirty_ff;
      pin_in    = pin_ff;
      rank_in   = rank_ff;
      fresh_in  = fresh_ff;
      top_in    = top_ff;
      hit_in    = hit_ff;
      hit_f_in  = hit_f_ff;
      vic_in    = vic_ff;
      vic_ok_in = vic_ok_ff;
      g_in      = g_ff;
      rem_in    = rem_ff;
      rem_r_in  = rem_r_ff;
      out_in    = out_ff;
      strobe_in = 1'b0;
      q_take    = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = g_ff;
      rd_addr   = FW'(idx_ff);
      pc        = '0;
      case (state_ff)
         S_IDLE: begin
            idx_in    = '0;
            hit_in    = 1'b0;
            vic_ok_in = 1'b0;
            top_in    = '0;
            if (q_valid) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // address idx issued now, data for idx-1 arrives
            if (idx_ff != '0) begin
               if (used_ff[scan_f] && rd_data == q_item.page_id && !hit_ff) begin
                  hit_in   = 1'b1;
                  hit_f_in = scan_f;
               end
               if (rank_ff[scan_f] == CW'(1)) begin
                  vic_ok_in = 1'b1;
                  vic_in    = scan_f;
               end
               if (rank_ff[scan_f] > top_ff) begin
                  top_in = rank_ff[scan_f];
               end
            end
            idx_in = idx_ff + CW'(1);
            if (idx_ff == CW'(FRAMES)) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            out_in   = '0;
            rem_in   = 1'b0;
            state_in = S_DONE;
            rd_addr  = vic_ff;
            if (q_item.req_type == pbpm_pkg::REQ_FETCH && hit_ff) begin
               if (&pin_ff[hit_f_ff]) begin
                  out_in.status = pbpm_pkg::ST_PIN_LIMIT;
               end else begin
                  pin_in[hit_f_ff]  = pin_ff[hit_f_ff] + PIN_BITS'(1);
                  out_in.frame_index = 4'(hit_f_ff);
                  rem_in   = rank_ff[hit_f_ff] != '0;
                  rem_r_in = rank_ff[hit_f_ff];
                  g_in     = hit_f_ff;
                  state_in = S_REM;
               end
            end else if (q_item.req_type == pbpm_pkg::REQ_FETCH ||
                         q_item.req_type == pbpm_pkg::REQ_NEW) begin
               if (fresh_ff < CW'(FRAMES)) begin
                  g_in     = FW'(fresh_ff);
                  fresh_in = fresh_ff + CW'(1);
               end else begin
                  g_in = vic_ff;
               end
               if (fresh_ff >= CW'(FRAMES) && !vic_ok_ff) begin
                  out_in.status = pbpm_pkg::ST_NO_FRAME;
               end else begin
                  out_in.frame_index  = 4'(g_in);
                  out_in.read_needed  = q_item.req_type == pbpm_pkg::REQ_FETCH;
                  out_in.clear_needed = q_item.req_type == pbpm_pkg::REQ_NEW;
                  if (fresh_ff >= CW'(FRAMES) && dirty_ff[vic_ff]) begin
                     out_in.write_needed = 1'b1;
                  end
                  if (q_item.req_type == pbpm_pkg::REQ_NEW && hit_ff) begin
                     used_in[hit_f_ff] = 1'b0;
                  end
                  used_in[g_in]  = 1'b1;
                  pin_in[g_in]   = PIN_BITS'(1);
                  dirty_in[g_in] = 1'b0;
                  rem_in   = rank_ff[g_in] != '0;
                  rem_r_in = rank_ff[g_in];
                  state_in = S_REM;
               end
            end else if (!hit_ff) begin
               out_in.status = pbpm_pkg::ST_NOT_RESIDENT;
            end else if (q_item.req_type == pbpm_pkg::REQ_UNPIN) begin
               if (pin_ff[hit_f_ff] == '0) begin
                  out_in.status = pbpm_pkg::ST_NOT_PINNED;
               end else begin
                  if (q_item.dirty) begin
                     dirty_in[hit_f_ff] = 1'b1;
                  end
                  pc = pin_ff[hit_f_ff] - PIN_BITS'(1);
                  pin_in[hit_f_ff] = pc;
                  if (pc == '0 && rank_ff[hit_f_ff] == '0) begin
                     rank_in[hit_f_ff] = top_ff + CW'(1);
                  end
                  out_in.frame_index = 4'(hit_f_ff);
               end
            end else begin
               out_in.write_needed  = 1'b1;
               out_in.write_page_id = q_item.page_id;
               dirty_in[hit_f_ff]   = 1'b0;
               out_in.frame_index   = 4'(hit_f_ff);
            end
         end
         S_REM: begin
            // victim page arrives from memory; page write happens here
            if (out_ff.write_needed) begin
               out_in.write_page_id = rd_data;
            end
            if (out_ff.read_needed || out_ff.clear_needed) begin
               wr_en = 1'b1;
            end
            if (rem_ff) begin
               for (int i = 0; i < FRAMES; i++) begin
                  if (rank_ff[i] > rem_r_ff) begin
                     rank_in[i] = rank_ff[i] - CW'(1);
                  end
               end
               rank_in[g_ff] = '0;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            strobe_in = 1'b1;
            q_take    = 1'b1;
            state_in  = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
         used_ff   <= '0;
         dirty_ff  <= '0;
         fresh_ff  <= '0;
         for (int i = 0; i < FRAMES; i++) begin
            pin_ff[i]  <= '0;
            rank_ff[i] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         used_ff   <= used_in;
         dirty_ff  <= dirty_in;
         fresh_ff  <= fresh_in;
         pin_ff    <= pin_in;
         rank_ff   <= rank_in;
      end
      idx_ff    <= idx_in;
      top_ff    <= top_in;
      hit_ff    <= hit_in;
      hit_f_ff  <= hit_f_in;
      vic_ff    <= vic_in;
      vic_ok_ff <= vic_ok_in;
      g_ff      <= g_in;
      rem_ff    <= rem_in;
      rem_r_ff  <= rem_r_in;
      out_ff    <= out_in;
   end
endmodule

// ===== rtl/page_buffer_pool_manager.sv =====
`timescale 1ns / 1ps
// Buffer pool manager for FRAMES page frames with LRU replacement. A request
// is taken when start is high and busy low; exactly one response follows on
// rsp_valid for one cycle and cannot be held off. Each request walks the page
// table memory one frame per cycle. The response follows the S_REM state when
// a frame is pinned or mapped, while an unpin, a flush or a refused request goes
// from S_DECIDE straight to S_DONE. busy falls while the response is on the
// ports, so the next request can be taken at the same edge as the response.
module page_buffer_pool_manager #(
   parameter int FRAMES   = 16,
   parameter int PIN_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  pbpm_pkg::req_type_type req_item,
   output logic                   busy,
   output logic                   rsp_valid,
   output pbpm_pkg::rsp_type      rsp_item
);
   logic                   q_valid, q_take;
   pbpm_pkg::req_type_type q_item;

   pbpm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_item (req_item),
      .busy     (busy),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_take   (q_take)
   );

   pbpm_engine #(.FRAMES(FRAMES), .PIN_BITS(PIN_BITS)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_take    (q_take),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );
endmodule

// ===== sim/pool_checker.sv =====
`timescale 1ns / 1ps
module pool_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  pbpm_pkg::req_type_type req_item,
   input  logic                   rsp_valid,
   input  pbpm_pkg::rsp_type      rsp_item,
   output int                     fail_count,
   output int                     pending_count,
   output int                     response_count
);
   localparam int NFRAMES = 16;
   localparam logic [15:0] PIN_LIMIT = 16'hffff;

   logic [31:0]       page_of [NFRAMES];
   logic              mapped [NFRAMES];
   logic [15:0]       pins [NFRAMES];
   logic              modified [NFRAMES];
   int                rank [NFRAMES];
   int                fresh_next;
   pbpm_pkg::rsp_type expected_responses[$];

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   function automatic int lookup(input logic [31:0] pid);
      for (int i = 0; i < NFRAMES; i++)
         if (mapped[i] && page_of[i] == pid) return i;
      return -1;
   endfunction

   function automatic void rank_drop(input int f);
      int r;
      r = rank[f];
      if (r == 0) return;
      for (int i = 0; i < NFRAMES; i++)
         if (rank[i] > r) rank[i]--;
      rank[f] = 0;
   endfunction

   function automatic pbpm_pkg::rsp_type apply_request(input pbpm_pkg::req_type_type rq);
      pbpm_pkg::rsp_type o;
      int f, g, top, old;
      o = '0;
      f = lookup(rq.page_id);
      if (rq.req_type == pbpm_pkg::REQ_FETCH && f >= 0) begin
         if (pins[f] == PIN_LIMIT) o.status = pbpm_pkg::ST_PIN_LIMIT;
         else begin
            pins[f]++;
            rank_drop(f);
            o.frame_index = 4'(f);
         end
      end else if (rq.req_type == pbpm_pkg::REQ_FETCH ||
                   rq.req_type == pbpm_pkg::REQ_NEW) begin
         g = -1;
         if (fresh_next < NFRAMES) begin
            g = fresh_next;
            fresh_next++;
         end else begin
            for (int i = 0; i < NFRAMES; i++)
               if (g < 0 && rank[i] == 1) g = i;
            if (g >= 0) begin
               rank_drop(g);
               if (modified[g]) begin
                  o.write_needed = 1'b1;
                  o.write_page_id = page_of[g];
                  modified[g] = 1'b0;
               end
               mapped[g] = 1'b0;
            end
         end
         if (g < 0) o.status = pbpm_pkg::ST_NO_FRAME;
         else begin
            if (rq.req_type == pbpm_pkg::REQ_NEW) begin
               old = lookup(rq.page_id);
               if (old >= 0) mapped[old] = 1'b0;
               o.clear_needed = 1'b1;
            end else o.read_needed = 1'b1;
            page_of[g] = rq.page_id;
            mapped[g] = 1'b1;
            pins[g] = 16'd1;
            modified[g] = 1'b0;
            rank_drop(g);
            o.frame_index = 4'(g);
         end
      end else if (f < 0) o.status = pbpm_pkg::ST_NOT_RESIDENT;
      else if (rq.req_type == pbpm_pkg::REQ_UNPIN) begin
         if (pins[f] == 0) o.status = pbpm_pkg::ST_NOT_PINNED;
         else begin
            if (rq.dirty) modified[f] = 1'b1;
            pins[f]--;
            if (pins[f] == 0 && rank[f] == 0) begin
               top = 0;
               for (int i = 0; i < NFRAMES; i++)
                  if (rank[i] > top) top = rank[i];
               rank[f] = top + 1;
            end
            o.frame_index = 4'(f);
         end
      end else begin
         o.write_needed = 1'b1;
         o.write_page_id = rq.page_id;
         modified[f] = 1'b0;
         o.frame_index = 4'(f);
      end
      return o;
   endfunction

   assign pending_count = expected_responses.size();

   always @(posedge clock) begin
      pbpm_pkg::rsp_type want;
      if (reset) begin
         for (int i = 0; i < NFRAMES; i++) begin
            mapped[i] = 1'b0; pins[i] = '0; modified[i] = 1'b0; rank[i] = 0; page_of[i] = '0;
         end
         fresh_next = 0;
         expected_responses.delete();
         fail_count = 0;
         response_count = 0;
      end else begin
         if (rsp_valid) begin
            response_count++;
            if (expected_responses.size() == 0) report("unexpected response", '0, '0);
            else begin
               want = expected_responses[0];
               expected_responses.delete(0);
               if (rsp_item.status !== want.status)
                  report("status", 32'(rsp_item.status), 32'(want.status));
               if (rsp_item.frame_index !== want.frame_index)
                  report("frame_index", 32'(rsp_item.frame_index), 32'(want.frame_index));
               if (rsp_item.read_needed !== want.read_needed)
                  report("read_needed", 32'(rsp_item.read_needed), 32'(want.read_needed));
               if (rsp_item.clear_needed !== want.clear_needed)
                  report("clear_needed", 32'(rsp_item.clear_needed), 32'(want.clear_needed));
               if (rsp_item.write_needed !== want.write_needed)
                  report("write_needed", 32'(rsp_item.write_needed), 32'(want.write_needed));
               if (rsp_item.write_page_id !== want.write_page_id)
                  report("write_page_id", rsp_item.write_page_id, want.write_page_id);
            end
         end
         if (start && !busy)
            expected_responses.insert(expected_responses.size(), apply_request(req_item));
      end
   end
endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
   logic                   clock;
   logic                   reset;
   logic                   start;
   pbpm_pkg::req_type_type req_item;
   logic                   busy;
   logic                   rsp_valid;
   pbpm_pkg::rsp_type      rsp_item;
   int                     fail_count, pending_count, response_count;
   int                     cycle_count;
   int                     page_hits[4];
   logic [31:0]            pool_ids[8];

   page_buffer_pool_manager u_top (
      .clock(clock), .reset(reset), .start(start), .req_item(req_item),
      .busy(busy), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

   pool_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_item(rsp_item), .fail_count(fail_count),
      .pending_count(pending_count), .response_count(response_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > 400000) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // hold start until the request is taken; start drops only when a gap follows
   task automatic send(input logic [1:0] kind, input logic [31:0] pid, input logic dflag);
      int gap;
      gap = $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_item <= '{req_type: kind, page_id: pid, dirty: dflag};
      @(posedge clock);
      while (busy) @(posedge clock);
      page_hits[kind]++;
   endtask

   initial begin
      logic [31:0] pid;
      int choice;
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      for (int i = 0; i < 4; i++) page_hits[i] = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: misses on empty pool, extreme ids, error paths
      send(pbpm_pkg::REQ_UNPIN, 32'd5, 1'b1);
      send(pbpm_pkg::REQ_FLUSH, 32'd5, 1'b0);
      send(pbpm_pkg::REQ_FETCH, 32'hffffffff, 1'b0);
      send(pbpm_pkg::REQ_FETCH, 32'd0, 1'b0);
      send(pbpm_pkg::REQ_FETCH, 32'hffffffff, 1'b0);
      send(pbpm_pkg::REQ_UNPIN, 32'hffffffff, 1'b1);
      send(pbpm_pkg::REQ_UNPIN, 32'hffffffff, 1'b0);
      send(pbpm_pkg::REQ_UNPIN, 32'hffffffff, 1'b0);
      send(pbpm_pkg::REQ_FLUSH, 32'hffffffff, 1'b0);
      send(pbpm_pkg::REQ_NEW, 32'd0, 1'b0);
      send(pbpm_pkg::REQ_NEW, 32'haaaaaaaa, 1'b0);
      send(pbpm_pkg::REQ_NEW, 32'h55555555, 1'b0);
      // fill every frame pinned, then ask for more
      for (int i = 0; i < 13; i++) send(pbpm_pkg::REQ_FETCH, 32'h100 + i, 1'b0);
      send(pbpm_pkg::REQ_FETCH, 32'h999, 1'b0);
      send(pbpm_pkg::REQ_NEW, 32'h998, 1'b0);

      // random: small id pool so hits, evictions and dirty write-backs all occur
      for (int i = 0; i < 8; i++) pool_ids[i] = $urandom;
      for (int n = 0; n < 930; n++) begin
         choice = $urandom_range(0, 99);
         if (choice < 80) pid = 32'h100 + $urandom_range(0, 23);
         else if (choice < 95) pid = pool_ids[$urandom_range(0, 7)];
         else pid = $urandom;
         send(2'($urandom_range(0, 3)), pid, 1'($urandom_range(0, 1)));
      end
      start <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      $display("requests: %0d fetch, %0d unpin, %0d flush, %0d new page",
               page_hits[0], page_hits[1], page_hits[2], page_hits[3]);
      $display("responses checked: %0d, mismatches: %0d", response_count, fail_count);
      if (fail_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end
endmodule

// ===== page_buffer_pool_manager.f =====
rtl/pbpm_pkg.sv
rtl/pbpm_ram.sv
rtl/pbpm_front.sv
rtl/pbpm_engine.sv
rtl/page_buffer_pool_manager.sv
sim/pool_checker.sv
sim/testbench.sv
